### rtl/slcp_pkg.sv
// shared constants and types for the serial line command parser
package slcp_pkg;

    // line buffer capacity and length counter width
    localparam int BUFFER_BYTES = 16;
    localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);

    // only the first bytes of a line can ever match a command
    localparam int MATCH_BYTES  = 4;
    localparam int MIDX_W       = $clog2(MATCH_BYTES);

    // control characters
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_DELETE    = 8'h7F;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    // response codes
    localparam logic [2:0] RSP_NONE    = 3'd0;
    localparam logic [2:0] RSP_ON      = 3'd1;
    localparam logic [2:0] RSP_OFF     = 3'd2;
    localparam logic [2:0] RSP_HELP    = 3'd3;
    localparam logic [2:0] RSP_EXIT    = 3'd4;
    localparam logic [2:0] RSP_INVALID = 3'd5;

    // one result word
    typedef struct packed {
        logic [2:0] response;
        logic       led_level;
        logic       exit_flag;
    } t_result;

endpackage

### rtl/slcp_line.sv
// line buffer, command match and led / exit state
module slcp_line
    import slcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_result    o_result
);

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_led;
    logic             n_led;
    logic             r_exit;
    logic             n_exit;
    logic [2:0]       n_rsp;
    logic [7:0]       r_store [MATCH_BYTES];
    logic             w_store_we;
    logic             w_is_on;
    logic             w_is_off;
    logic             w_is_help;
    logic             w_is_exit;

    // fixed compares of the head of the line
    assign w_is_on   = (r_len == LEN_W'(2)) && (r_store[0] == "o") && (r_store[1] == "n");
    assign w_is_off  = (r_len == LEN_W'(3)) && (r_store[0] == "o") && (r_store[1] == "f")
                       && (r_store[2] == "f");
    assign w_is_help = (r_len == LEN_W'(4)) && (r_store[0] == "h") && (r_store[1] == "e")
                       && (r_store[2] == "l") && (r_store[3] == "p");
    assign w_is_exit = (r_len == LEN_W'(4)) && (r_store[0] == "e") && (r_store[1] == "x")
                       && (r_store[2] == "i") && (r_store[3] == "t");

    // next state and response for this byte
    always_comb begin
        n_len      = r_len;
        n_led      = r_led;
        n_exit     = r_exit;
        n_rsp      = RSP_NONE;
        w_store_we = 1'b0;
        if ((i_rx_byte == CH_BACKSPACE) || (i_rx_byte == CH_DELETE)) begin
            if (r_len != '0) begin
                n_len = r_len - LEN_W'(1);
            end
        end else if (i_rx_byte == CH_RETURN) begin
            n_len = '0;
            if (w_is_on) begin
                n_led = 1'b1;
                n_rsp = RSP_ON;
            end else if (w_is_off) begin
                n_led = 1'b0;
                n_rsp = RSP_OFF;
            end else if (w_is_help) begin
                n_rsp = RSP_HELP;
            end else if (w_is_exit) begin
                n_exit = 1'b1;
                n_rsp  = RSP_EXIT;
            end else begin
                n_rsp = RSP_INVALID;
            end
        end else if (r_len < LEN_W'(BUFFER_BYTES)) begin
            n_len      = r_len + LEN_W'(1);
            w_store_we = (r_len < LEN_W'(MATCH_BYTES));
        end
    end

    assign o_result.response  = n_rsp;
    assign o_result.led_level = n_led;
    assign o_result.exit_flag = n_exit;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_led  <= 1'b0;
            r_exit <= 1'b0;
        end else if (i_accept) begin
            r_len  <= n_len;
            r_led  <= n_led;
            r_exit <= n_exit;
        end
    end

    // head of line store, bytes past the match window are only counted
    always_ff @(posedge i_clk) begin
        if (i_accept && w_store_we) begin
            r_store[r_len[MIDX_W-1:0]] <= i_rx_byte;
        end
    end

    // length never exceeds the buffer
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(BUFFER_BYTES))
        else $error("line length above buffer size");

    // carriage return always empties the line
    a_cr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_rx_byte == CH_RETURN)) |=> (r_len == '0))
        else $error("line not cleared after return");

    // exit flag is sticky
    a_exit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exit |=> r_exit)
        else $error("exit flag dropped");

    // only a return gives a nonzero response
    a_rsp_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_rsp != RSP_NONE) |-> (i_rx_byte == CH_RETURN))
        else $error("response without return");

endmodule

### rtl/slcp_out_buf.sv
// two-word result buffer between the parser and the output channel
module slcp_out_buf
    import slcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_space  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign w_pop    = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    // never push into a full buffer
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !i_push)
        else $error("push into full buffer");

    // count agrees with pointers
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("pointer and count mismatch");

    // a held word stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result)))
        else $error("output word changed while stalled");

endmodule

### rtl/serial_line_command_parser_top.sv
// Serial line command parser: takes one received byte per word on the input channel and
// returns one result word per byte (response, led level, exit flag). A byte is taken in
// the cycle it arrives and its result is written to a two-word output buffer in the same
// edge, so one byte per clock is sustained; input ready drops only while both buffer
// words wait on the output side. The result is registered and waits behind older buffer words.
module serial_line_command_parser_top
    import slcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_response,
    output logic       o_led_level,
    output logic       o_exit_flag
);

    t_result w_line_res;
    t_result w_out_res;
    logic    w_accept;
    logic    w_space;

    assign o_ready  = w_space;
    assign w_accept = i_valid && w_space;

    // line buffer and command decode
    slcp_line u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_result  (w_line_res)
    );

    // result buffer
    slcp_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_result (w_line_res),
        .o_space  (w_space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_out_res)
    );

    assign o_response  = w_out_res.response;
    assign o_led_level = w_out_res.led_level;
    assign o_exit_flag = w_out_res.exit_flag;

endmodule

### test/serial_line_command_parser_top_tb.sv
// testbench for the serial line command parser: directed and random lines, scoreboard checked
`timescale 1ns / 100ps

module serial_line_command_parser_top_tb;
    import slcp_pkg::*;

    localparam int RANDOM_WORDS   = 600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_WAIT       = 18;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic [2:0] o_response;
    logic       o_led_level;
    logic       o_exit_flag;

    serial_line_command_parser_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_response  (o_response),
        .o_led_level (o_led_level),
        .o_exit_flag (o_exit_flag)
    );

    // shadow state of the parser
    logic [7:0] line_buf [BUFFER_BYTES];
    int         line_len   = 0;
    logic       led_state  = 1'b0;
    logic       exit_state = 1'b0;

    // responses still owed by the block, oldest first
    t_result    results_due[$];

    int  err_count   = 0;
    int  words_sent  = 0;
    int  words_back  = 0;
    int  rsp_count [6];
    int  idle_cycles = 0;
    bit  gaps_on     = 1'b1;
    bit  stalls_on   = 1'b1;

    string cmd_words [4] = '{"on", "off", "help", "exit"};

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // true when the buffered line is exactly the given text
    function automatic bit line_holds(input string w);
        int i;
        if (line_len != w.len())
            return 1'b0;
        for (i = 0; i < w.len(); i++) begin
            if (line_buf[i] != w[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the shadow state by one byte and give the result word it causes
    function automatic t_result next_result(input logic [7:0] ch);
        t_result r;
        r.response = RSP_NONE;
        if (ch == CH_BACKSPACE || ch == CH_DELETE) begin
            if (line_len > 0)
                line_len--;
        end else if (ch == CH_RETURN) begin
            if (line_holds("on")) begin
                led_state  = 1'b1;
                r.response = RSP_ON;
            end else if (line_holds("off")) begin
                led_state  = 1'b0;
                r.response = RSP_OFF;
            end else if (line_holds("help")) begin
                r.response = RSP_HELP;
            end else if (line_holds("exit")) begin
                exit_state = 1'b1;
                r.response = RSP_EXIT;
            end else begin
                r.response = RSP_INVALID;
            end
            line_len = 0;
        end else if (line_len < BUFFER_BYTES) begin
            line_buf[line_len] = ch;
            line_len++;
        end
        r.led_level = led_state;
        r.exit_flag = exit_state;
        return r;
    endfunction

    // check result words against the oldest prediction, then record accepted bytes
    always @(posedge i_clk) begin : check_proc
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                words_back++;
                if (results_due.size() == 0) begin
                    err_count++;
                    $display("%0t: result word with none pending: response %0d led %0b exit %0b",
                             $time, o_response, o_led_level, o_exit_flag);
                end else begin
                    want = results_due.pop_front();
                    if (o_response !== want.response) begin
                        err_count++;
                        $display("%0t: response expected %0d actual %0d",
                                 $time, want.response, o_response);
                    end
                    if (o_led_level !== want.led_level) begin
                        err_count++;
                        $display("%0t: led_level expected %0b actual %0b",
                                 $time, want.led_level, o_led_level);
                    end
                    if (o_exit_flag !== want.exit_flag) begin
                        err_count++;
                        $display("%0t: exit_flag expected %0b actual %0b",
                                 $time, want.exit_flag, o_exit_flag);
                    end
                end
            end
            if (i_valid && o_ready) begin
                want = next_result(i_rx_byte);
                rsp_count[want.response]++;
                results_due.push_back(want);
            end
        end
    end

    // watchdog on cycles where neither channel moves a word
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("serial_line_command_parser_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output side: random stall before each result word, with stall-free stretches
    initial begin : sink_proc
        int stall;
        forever begin
            stall = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
            if ($urandom_range(0, 29) == 0)
                stalls_on = !stalls_on;
        end
    end

    // present one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // any byte that is not an edit key or carriage return
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_BACKSPACE || b == CH_DELETE || b == CH_RETURN);
        return b;
    endfunction

    function automatic logic [7:0] edit_key();
        return $urandom_range(0, 1) ? CH_BACKSPACE : CH_DELETE;
    endfunction

    // edit keys on an empty line, then a typo corrected before return
    task automatic test_line_editing();
        send_byte(CH_BACKSPACE);
        send_byte(CH_DELETE);
        send_text("ox");
        send_byte(CH_BACKSPACE);
        send_byte("n");
        send_byte(CH_RETURN);
    endtask

    // the remaining commands spelled plainly
    task automatic test_commands();
        send_text("off");
        send_byte(CH_RETURN);
        send_text("help");
        send_byte(CH_RETURN);
        send_text("exit");
        send_byte(CH_RETURN);
    endtask

    // empty line and lines holding the extreme byte values
    task automatic test_odd_lines();
        send_byte(CH_RETURN);
        send_byte(8'h00);
        send_byte(CH_RETURN);
        send_byte(8'hFF);
        send_byte(CH_RETURN);
    endtask

    // mostly command lines with noise, typos, overflow and leftover text mixed in
    task automatic test_random_lines();
        int    stop_at;
        int    kind;
        int    n;
        int    k;
        string w;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                gaps_on = !gaps_on;
            kind = $urandom_range(0, 9);
            w    = cmd_words[$urandom_range(0, 3)];
            case (kind)
                0, 1, 2, 3: begin
                    // command, sometimes with a typo fixed in the middle
                    if ($urandom_range(0, 2) == 0) begin
                        k = $urandom_range(0, w.len());
                        send_text(w.substr(0, k - 1));
                        send_byte(plain_byte());
                        send_byte(edit_key());
                        send_text(w.substr(k, w.len() - 1));
                    end else begin
                        send_text(w);
                    end
                    send_byte(CH_RETURN);
                end
                4: begin
                    // near miss: one flipped bit or an extra character
                    if ($urandom_range(0, 1)) begin
                        k = $urandom_range(0, w.len() - 1);
                        w.putc(k, w[k] ^ (8'h01 << $urandom_range(0, 7)));
                        send_text(w);
                    end else begin
                        send_text(w);
                        send_byte(plain_byte());
                    end
                    send_byte(CH_RETURN);
                end
                5: begin
                    // run the line to near the buffer's end or past it
                    n = $urandom_range(BUFFER_BYTES - 2, BUFFER_BYTES + 5);
                    repeat (n) send_byte(plain_byte());
                    if ($urandom_range(0, 1)) begin
                        send_byte(edit_key());
                        send_byte(plain_byte());
                    end
                    send_byte(CH_RETURN);
                end
                6: begin
                    // raw noise, control characters included
                    n = $urandom_range(0, 8);
                    repeat (n) send_byte(8'($urandom_range(0, 255)));
                    send_byte(CH_RETURN);
                end
                7: begin
                    // erase at least as much as was typed, then a clean command
                    send_text(w);
                    repeat (w.len() + $urandom_range(0, 3)) send_byte(edit_key());
                    send_text(w);
                    send_byte(CH_RETURN);
                end
                8: begin
                    // bare return or edits only
                    n = $urandom_range(0, 2);
                    repeat (n) send_byte(edit_key());
                    send_byte(CH_RETURN);
                end
                default: begin
                    // text left without a return runs into the next line
                    send_text(w);
                end
            endcase
        end
        send_byte(CH_RETURN);
    endtask

    initial begin : main_proc
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_line_editing();
        test_commands();
        test_odd_lines();
        test_random_lines();

        // drain: wait until every byte sent has its result word back
        i_valid <= 1'b0;
        while (words_back < words_sent)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("sent %0d bytes, checked %0d result words", words_sent, words_back);
        $display("responses seen: none %0d on %0d off %0d help %0d exit %0d invalid %0d",
                 rsp_count[RSP_NONE], rsp_count[RSP_ON], rsp_count[RSP_OFF],
                 rsp_count[RSP_HELP], rsp_count[RSP_EXIT], rsp_count[RSP_INVALID]);
        if (err_count == 0) begin
            $display("serial_line_command_parser_top verification clean");
        end else begin
            $display("serial_line_command_parser_top verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/slcp_pkg.sv
rtl/slcp_line.sv
rtl/slcp_out_buf.sv
rtl/serial_line_command_parser_top.sv
test/serial_line_command_parser_top_tb.sv
